>>> rtl/i2c_rm_pkg.sv
// Shared types and constants for the I2C register master.
// Holds the word structs, configuration struct, phase enum and reset values.
// No dependencies.
package i2c_rm_pkg;

    // One tick word: an optional request plus the sampled SDA level.
    typedef struct packed {
        logic       req_valid;
        logic       func;
        logic [6:0] dev_addr;
        logic [7:0] sub_addr;
        logic [7:0] wr_data;
        logic       sda_in;
    } t_in_word;

    // One result word: line levels and status after the tick.
    typedef struct packed {
        logic       scl_out;
        logic       sda_pull_low;
        logic       busy_res;
        logic       done_res;
        logic       nack_error;
        logic [7:0] rd_data;
    } t_out_word;

    // Live configuration handed to the bus engine.
    typedef struct packed {
        logic [15:0] half_period_ticks;
        logic [7:0]  ack_timeout;
    } t_cfg;

    // Bus engine phases.
    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_START_A   = 4'd1,
        PH_START_B   = 4'd2,
        PH_BIT_LOW   = 4'd3,
        PH_BIT_HIGH  = 4'd4,
        PH_ACK_LOW   = 4'd5,
        PH_ACK_HIGH  = 4'd6,
        PH_RD_LOW    = 4'd7,
        PH_RD_HIGH   = 4'd8,
        PH_NACK_LOW  = 4'd9,
        PH_NACK_HIGH = 4'd10,
        PH_RS_A      = 4'd11,
        PH_RS_B      = 4'd12,
        PH_STOP_A    = 4'd13,
        PH_STOP_B    = 4'd14,
        PH_STOP_C    = 4'd15
    } t_phase;

    // Which byte of the transfer is in flight.
    typedef logic [1:0] t_step;
    localparam t_step STEP_DEV  = 2'd0;
    localparam t_step STEP_REG  = 2'd1;
    localparam t_step STEP_DATA = 2'd2;
    localparam t_step STEP_READ = 2'd3;

    localparam logic FUNC_READ = 1'b1;

    // Configuration register indexes and widths.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 1'b1;

    localparam logic [15:0] HALF_PERIOD_RESET = 16'd500;
    localparam logic [7:0]  ACK_TIMEOUT_RESET = 8'd250;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;
    localparam int QUEUE_DEPTH_DEFAULT = 2;

endpackage

>>> rtl/i2c_rm_queue.sv
// Front part of the I2C register master: accepts tick words into a short queue.
// Depends on i2c_rm_pkg for the word type.
// The queue lets the input and the bus engine stall independently.
module i2c_rm_queue
    import i2c_rm_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push_valid,
    output logic     o_push_ready,
    input  t_in_word i_push_word,
    output logic     o_pop_valid,
    input  logic     i_pop,
    output t_in_word o_pop_word
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_in_word         r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;
    logic             push;
    logic             pop;

    assign o_push_ready = (r_count != FULL_CNT);
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_word   = r_mem[r_rd_ptr];
    assign push = i_push_valid && o_push_ready;
    assign pop  = i_pop && o_pop_valid;

    // Pointer and fill count updates.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (push && !pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (pop && !push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage needs no reset; the fill count guards it.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_word;
        end
    end

endmodule

>>> rtl/i2c_rm_engine.sv
// Back part of the I2C register master: the bus phase sequencer.
// Depends on i2c_rm_pkg. Takes one tick word per step and registers
// the resulting line levels and status in an output stage.
module i2c_rm_engine
    import i2c_rm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_word_valid,
    output logic      o_word_pop,
    input  t_in_word  i_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    t_phase      r_phase, n_phase;
    logic [15:0] r_tick, n_tick;
    logic [3:0]  r_bit, n_bit;
    t_step       r_step, n_step;
    logic [7:0]  r_shift, n_shift;
    logic [8:0]  r_polls, n_polls;
    logic        r_func, n_func;
    logic [6:0]  r_dev, n_dev;
    logic [7:0]  r_reg, n_reg;
    logic [7:0]  r_data, n_data;
    logic [7:0]  r_rd_byte, n_rd_byte;
    logic        r_err, n_err;
    logic        n_done;

    logic        r_out_valid;
    t_out_word   r_out_word;
    t_out_word   n_out_word;

    logic        step_en;
    logic [15:0] tick_inc;
    logic        seg_over;
    logic [15:0] tick_seg;
    logic [3:0]  bit_inc;
    logic [8:0]  polls_inc;

    // A step happens when a word waits and the output stage can take its result.
    assign step_en    = i_word_valid && (!r_out_valid || i_out_ready);
    assign o_word_pop = step_en;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // Segment timer: the segment ends when the count reaches the half period.
    assign tick_inc  = r_tick + 16'd1;
    assign seg_over  = (tick_inc >= i_cfg.half_period_ticks) || (tick_inc == 16'd0);
    assign tick_seg  = seg_over ? 16'd0 : tick_inc;
    assign bit_inc   = r_bit + 4'd1;
    assign polls_inc = r_polls + 9'd1;

    // Next state for one tick.
    always_comb begin
        n_phase   = r_phase;
        n_tick    = r_tick;
        n_bit     = r_bit;
        n_step    = r_step;
        n_shift   = r_shift;
        n_polls   = r_polls;
        n_func    = r_func;
        n_dev     = r_dev;
        n_reg     = r_reg;
        n_data    = r_data;
        n_rd_byte = r_rd_byte;
        n_err     = r_err;
        n_done    = 1'b0;
        case (r_phase)
            PH_IDLE: begin
                if (i_word.req_valid) begin
                    n_func    = i_word.func;
                    n_dev     = i_word.dev_addr;
                    n_reg     = i_word.sub_addr;
                    n_data    = i_word.wr_data;
                    n_tick    = 16'd0;
                    n_bit     = 4'd0;
                    n_step    = STEP_DEV;
                    n_polls   = 9'd0;
                    n_rd_byte = 8'd0;
                    n_err     = 1'b0;
                    n_phase   = PH_START_A;
                end
            end
            PH_START_A: begin
                n_tick = tick_seg;
                if (seg_over) begin
                    n_phase = PH_START_B;
                end
            end
            PH_START_B: begin
                n_tick = tick_seg;
                if (seg_over) begin
                    n_shift = {r_dev, (r_step == STEP_DATA)};
                    n_bit   = 4'd0;
                    n_phase = PH_BIT_LOW;
                end
            end
            PH_BIT_LOW: begin
                n_tick = tick_seg;
                if (seg_over) begin
                    n_phase = PH_BIT_HIGH;
                end
            end
            PH_BIT_HIGH: begin
                n_tick = tick_seg;
                if (seg_over) begin
                    n_shift = {r_shift[6:0], 1'b0};
                    if (bit_inc >= BITS_PER_BYTE) begin
                        n_bit   = 4'd0;
                        n_phase = PH_ACK_LOW;
                    end else begin
                        n_bit   = bit_inc;
                        n_phase = PH_BIT_LOW;
                    end
                end
            end
            PH_ACK_LOW: begin
                n_tick = tick_seg;
                if (seg_over) begin
                    n_polls = 9'd0;
                    n_phase = PH_ACK_HIGH;
                end
            end
            PH_ACK_HIGH: begin
                if (!i_word.sda_in) begin
                    // Slave acknowledged: move on to the next byte or phase.
                    n_tick  = 16'd0;
                    n_polls = 9'd0;
                    if (r_step == STEP_DEV) begin
                        n_step  = STEP_REG;
                        n_shift = r_reg;
                        n_bit   = 4'd0;
                        n_phase = PH_BIT_LOW;
                    end else if (r_step == STEP_REG) begin
                        if (r_func == FUNC_READ) begin
                            n_phase = PH_RS_A;
                        end else begin
                            n_step  = STEP_DATA;
                            n_shift = r_data;
                            n_bit   = 4'd0;
                            n_phase = PH_BIT_LOW;
                        end
                    end else if (r_step == STEP_DATA && r_func == FUNC_READ) begin
                        n_step  = STEP_READ;
                        n_bit   = 4'd0;
                        n_phase = PH_RD_LOW;
                    end else begin
                        n_phase = PH_STOP_A;
                    end
                end else begin
                    n_polls = polls_inc;
                    if (polls_inc > {1'b0, i_cfg.ack_timeout}) begin
                        n_err   = 1'b1;
                        n_polls = 9'd0;
                        n_tick  = 16'd0;
                        n_phase = PH_STOP_A;
                    end
                end
            end
            PH_RD_LOW: begin
                n_tick = tick_seg;
                if (seg_over) begin
                    n_phase = PH_RD_HIGH;
                end
            end
            PH_RD_HIGH: begin
                n_tick = tick_seg;
                if (seg_over) begin
                    n_rd_byte = {r_rd_byte[6:0], i_word.sda_in};
                    if (bit_inc >= BITS_PER_BYTE) begin
                        n_bit   = 4'd0;
                        n_phase = PH_NACK_LOW;
                    end else begin
                        n_bit   = bit_inc;
                        n_phase = PH_RD_LOW;
                    end
                end
            end
            PH_NACK_LOW: begin
                n_tick = tick_seg;
                if (seg_over) begin
                    n_phase = PH_NACK_HIGH;
                end
            end
            PH_NACK_HIGH: begin
                n_tick = tick_seg;
                if (seg_over) begin
                    n_phase = PH_STOP_A;
                end
            end
            PH_RS_A: begin
                n_tick = tick_seg;
                if (seg_over) begin
                    n_phase = PH_RS_B;
                end
            end
            PH_RS_B: begin
                n_tick = tick_seg;
                if (seg_over) begin
                    n_step  = STEP_DATA;
                    n_phase = PH_START_B;
                end
            end
            PH_STOP_A: begin
                n_tick = tick_seg;
                if (seg_over) begin
                    n_phase = PH_STOP_B;
                end
            end
            PH_STOP_B: begin
                n_tick = tick_seg;
                if (seg_over) begin
                    n_phase = PH_STOP_C;
                end
            end
            PH_STOP_C: begin
                n_tick = tick_seg;
                if (seg_over) begin
                    n_phase = PH_IDLE;
                    n_done  = 1'b1;
                end
            end
            default: begin
                n_phase = PH_IDLE;
                n_tick  = 16'd0;
            end
        endcase
    end

    // Line levels and status for the phase entered on this tick.
    always_comb begin
        n_out_word.scl_out      = 1'b1;
        n_out_word.sda_pull_low = 1'b0;
        case (n_phase)
            PH_START_B: begin
                n_out_word.sda_pull_low = 1'b1;
            end
            PH_BIT_LOW: begin
                n_out_word.scl_out      = 1'b0;
                n_out_word.sda_pull_low = !n_shift[7];
            end
            PH_BIT_HIGH: begin
                n_out_word.sda_pull_low = !n_shift[7];
            end
            PH_ACK_LOW, PH_RD_LOW, PH_NACK_LOW, PH_RS_A: begin
                n_out_word.scl_out = 1'b0;
            end
            PH_STOP_A: begin
                n_out_word.scl_out      = 1'b0;
                n_out_word.sda_pull_low = 1'b1;
            end
            PH_STOP_B: begin
                n_out_word.sda_pull_low = 1'b1;
            end
            default: begin
                n_out_word.scl_out = 1'b1;
            end
        endcase
        n_out_word.busy_res   = (n_phase != PH_IDLE);
        n_out_word.done_res   = n_done;
        n_out_word.nack_error = n_done && n_err;
        n_out_word.rd_data    = (n_done && (n_func == FUNC_READ) && !n_err)
                              ? n_rd_byte : 8'd0;
    end

    // Sequencer state advances once per consumed word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_tick    <= 16'd0;
            r_bit     <= 4'd0;
            r_step    <= STEP_DEV;
            r_shift   <= 8'd0;
            r_polls   <= 9'd0;
            r_func    <= 1'b0;
            r_dev     <= 7'd0;
            r_reg     <= 8'd0;
            r_data    <= 8'd0;
            r_rd_byte <= 8'd0;
            r_err     <= 1'b0;
        end else if (step_en) begin
            r_phase   <= n_phase;
            r_tick    <= n_tick;
            r_bit     <= n_bit;
            r_step    <= n_step;
            r_shift   <= n_shift;
            r_polls   <= n_polls;
            r_func    <= n_func;
            r_dev     <= n_dev;
            r_reg     <= n_reg;
            r_data    <= n_data;
            r_rd_byte <= n_rd_byte;
            r_err     <= n_err;
        end
    end

    // Output stage: holds a result word until the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step_en) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_en) begin
            r_out_word <= n_out_word;
        end
    end

    // The sequencer returns to idle right after a completion is produced.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step_en && n_done) |=> (r_phase == PH_IDLE))
        else $error("phase not idle after transfer completion");

    // The busy flag in a fresh result word matches the stored phase.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step_en |=> (r_out_word.busy_res == (r_phase != PH_IDLE)))
        else $error("busy flag disagrees with phase");

    // The bit counter is cleared before it reaches a full byte.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit < BITS_PER_BYTE)
        else $error("bit counter overflow");

    // Error and read data are only reported together with completion.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_word.nack_error || (r_out_word.rd_data != 8'd0)))
        |-> r_out_word.done_res)
        else $error("status reported without completion");

endmodule

>>> rtl/i2c_register_master_unit.sv
// I2C register master: one tick word in, one result word out.
// Input words carry an optional register read or write request and the
// sampled SDA level; each accepted word yields exactly one result word with
// the SCL and SDA drive levels, busy, a one-word done pulse, the ACK error
// flag and the byte read.
// Words pass a short input queue, then the bus sequencer, which advances one
// step per word, then a one-word output register. When nothing stalls, an
// accepted word is written into the queue, popped by the sequencer, and its
// result is registered in the output register, where it is offered; one word
// per cycle is sustained: each sequencer step is a 16-bit segment count and
// compare plus a phase decode, done combinationally.
// If the receiver stalls, the output register holds its word and the queue
// keeps accepting until it is full; then ready drops.
// Reset clears the queue, the output register and the sequencer to idle, and
// loads a half period of 500 ticks and an ACK timeout of 250 polls.
// Configuration writes take effect at the next edge and belong to idle
// periods. Depends on i2c_rm_pkg, i2c_rm_queue and i2c_rm_engine.
module i2c_register_master_unit
    import i2c_rm_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_word              i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_word             o_out_word,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [15:0] r_half_period;
    logic [7:0]  r_ack_timeout;
    t_cfg        cfg;
    logic        q_valid;
    logic        q_pop;
    t_in_word    q_word;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= HALF_PERIOD_RESET;
            r_ack_timeout <= ACK_TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_HALF_PERIOD: r_half_period <= i_cfg_data[15:0];
                CFG_ACK_TIMEOUT: r_ack_timeout <= i_cfg_data[7:0];
                default: r_half_period <= r_half_period;
            endcase
        end
    end

    assign cfg.half_period_ticks = r_half_period;
    assign cfg.ack_timeout       = r_ack_timeout;

    // Input queue.
    i2c_rm_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (i_in_valid),
        .o_push_ready (o_in_ready),
        .i_push_word  (i_in_word),
        .o_pop_valid  (q_valid),
        .i_pop        (q_pop),
        .o_pop_word   (q_word)
    );

    // Bus sequencer with its output register.
    i2c_rm_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_word_valid (q_valid),
        .o_word_pop   (q_pop),
        .i_word       (q_word),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_word   (o_out_word)
    );

endmodule
